### sv/karx_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// karx_pkg
// Types, constants and helpers shared by the keyed ARX hash unit.
// ----------------------------------------------------------------------------
package karx_pkg;

    localparam int WORD_W = 64;

    typedef logic [WORD_W-1:0] word_t;

    localparam word_t INIT_V0 = 64'h736f6d6570736575;
    localparam word_t INIT_V1 = 64'h646f72616e646f6d;
    localparam word_t INIT_V2 = 64'h6c7967656e657261;
    localparam word_t INIT_V3 = 64'h7465646279746573;
    localparam word_t FINAL_MARK = 64'h00000000000000ff;

    localparam int ROT_A_FIRST  = 13;
    localparam int ROT_C_FIRST  = 16;
    localparam int ROT_A_SECOND = 17;
    localparam int ROT_C_SECOND = 21;
    localparam int ROT_HALF     = 32;

    typedef enum logic
    {
        KEY_LOW_IDX  = 1'b0,
        KEY_HIGH_IDX = 1'b1
    } cfg_index_t;

    typedef struct packed
    {
        logic  valid;
        word_t msg;
        word_t v0;
        word_t v1;
        word_t v2;
        word_t v3;
    } stage_t;

    function automatic word_t rotl(input word_t x, input int n);
        word_t r;
        r = (x << n) | (x >> (WORD_W - n));
        return r;
    endfunction

endpackage

### sv/karx_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// karx_msg_if / karx_tag_if
// Valid/ready channels for message words in and hash tags out.
// ----------------------------------------------------------------------------
interface karx_msg_if;
    logic        valid;
    logic        ready;
    logic [63:0] message;

    modport source (output valid, output message, input ready);
    modport sink   (input valid, input message, output ready);
endinterface

interface karx_tag_if;
    logic        valid;
    logic        ready;
    logic [63:0] tag;

    modport source (output valid, output tag, input ready);
    modport sink   (input valid, input tag, output ready);
endinterface

### sv/karx_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// karx_cell
// One half of a SipRound: two adds, two rotate-XORs and a half-word swap,
// registered. Even cells take the first half, odd cells the second.
// ----------------------------------------------------------------------------
module karx_cell
    import karx_pkg::*;
#(
    parameter bit SECOND_HALF = 1'b0
)
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   advance,
    input  stage_t stage_in,
    output stage_t stage_out
);

    localparam int ROT_B = SECOND_HALF ? ROT_A_SECOND : ROT_A_FIRST;
    localparam int ROT_D = SECOND_HALF ? ROT_C_SECOND : ROT_C_FIRST;

    word_t a;
    word_t b;
    word_t c;
    word_t d;
    word_t a_sum;
    word_t c_sum;
    word_t a_next;
    word_t b_next;
    word_t c_next;
    word_t d_next;

    logic  valid_reg;
    word_t msg_reg;
    word_t v0_reg;
    word_t v1_reg;
    word_t v2_reg;
    word_t v3_reg;

    always_comb
    begin
        if (SECOND_HALF)
        begin
            a = stage_in.v2;
            c = stage_in.v0;
        end
        else
        begin
            a = stage_in.v0;
            c = stage_in.v2;
        end
        b = stage_in.v1;
        d = stage_in.v3;

        a_sum  = a + b;
        c_sum  = c + d;
        b_next = rotl(b, ROT_B) ^ a_sum;
        d_next = rotl(d, ROT_D) ^ c_sum;
        a_next = rotl(a_sum, ROT_HALF);
        c_next = c_sum;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= stage_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            msg_reg <= stage_in.msg;
            v1_reg  <= b_next;
            v3_reg  <= d_next;
            if (SECOND_HALF)
            begin
                v0_reg <= c_next;
                v2_reg <= a_next;
            end
            else
            begin
                v0_reg <= a_next;
                v2_reg <= c_next;
            end
        end
    end

    assign stage_out = '{valid: valid_reg, msg: msg_reg,
                         v0: v0_reg, v1: v1_reg, v2: v2_reg, v3: v3_reg};

endmodule

### sv/keyed_arx_hash_single_block_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyed_arx_hash_single_block_unit
// Keyed SipHash-style hash of one 64-bit word, built as a chain of half-round
// cells with the message and finalisation mixes between them.
//
//   Channel  Dir  Payload          Transaction when
//   msg      in   message[63:0]    msg.valid & msg.ready
//   hash     out  tag[63:0]        hash.valid & hash.ready
//   cfg      in   cfg_wr_data      cfg_wr_en (index 0 key_low, 1 key_high)
//
// One message per cycle sustained while hash.ready keeps up; each message passes
// through 2*(COMPRESS_ROUNDS+FINAL_ROUNDS) half-round cells, then the tag register.
// The whole chain moves as one: a stalled tag holds every cell and msg.ready.
// Reset clears the key registers and all valid flags.
// ----------------------------------------------------------------------------
module keyed_arx_hash_single_block_unit
    import karx_pkg::*;
#(
    parameter int COMPRESS_ROUNDS = 2,
    parameter int FINAL_ROUNDS    = 1
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wr_en,
    input  cfg_index_t           cfg_index,
    input  logic [WORD_W-1:0]    cfg_wr_data,
    karx_msg_if.sink             msg,
    karx_tag_if.source           hash
);

    localparam int NUM_CELLS  = 2 * (COMPRESS_ROUNDS + FINAL_ROUNDS);
    localparam int FINAL_CELL = 2 * COMPRESS_ROUNDS;

    word_t  key_low_reg;
    word_t  key_high_reg;
    word_t  tag_reg;
    logic   tag_valid_reg;
    logic   advance;
    stage_t stage [0:NUM_CELLS];
    stage_t cell_in [0:NUM_CELLS-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_low_reg  <= '0;
            key_high_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                KEY_LOW_IDX:  key_low_reg  <= cfg_wr_data;
                KEY_HIGH_IDX: key_high_reg <= cfg_wr_data;
                default:      key_low_reg  <= key_low_reg;
            endcase
        end
    end

    assign advance   = !tag_valid_reg || hash.ready;
    assign msg.ready = advance;

    assign stage[0] = '{valid: msg.valid, msg: msg.message,
                        v0: INIT_V0 ^ key_low_reg,
                        v1: INIT_V1 ^ key_high_reg,
                        v2: INIT_V2 ^ key_low_reg,
                        v3: INIT_V3 ^ key_high_reg ^ msg.message};

    for (genvar k = 0; k < NUM_CELLS; k++)
    begin : g_cell
        if (k == FINAL_CELL)
        begin : g_mix
            assign cell_in[k] = '{valid: stage[k].valid, msg: stage[k].msg,
                                  v0: stage[k].v0 ^ stage[k].msg,
                                  v1: stage[k].v1,
                                  v2: stage[k].v2 ^ FINAL_MARK,
                                  v3: stage[k].v3};
        end
        else
        begin : g_pass
            assign cell_in[k] = stage[k];
        end

        karx_cell #(
            .SECOND_HALF ((k % 2) == 1)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .advance   (advance),
            .stage_in  (cell_in[k]),
            .stage_out (stage[k+1])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            tag_valid_reg <= stage[NUM_CELLS].valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            tag_reg <= stage[NUM_CELLS].v0 ^ stage[NUM_CELLS].v1
                     ^ stage[NUM_CELLS].v2 ^ stage[NUM_CELLS].v3;
        end
    end

    assign hash.valid = tag_valid_reg;
    assign hash.tag   = tag_reg;

endmodule
